// ===== hw/rtl/wtrp_pkg.sv =====
// wtrp_pkg: shared types, constants and wavetables for the wavetable tone,
// record and playback block. No dependencies; used by ctrl, duty and top.
`default_nettype none

package wtrp_pkg;

  typedef enum logic [1:0] {
    MODE_TONE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_e;

  // how the compare value of an item is formed
  typedef enum logic [1:0] {
    DUTY_ZERO  = 2'd0,
    DUTY_HOLD  = 2'd1,
    DUTY_TABLE = 2'd2,
    DUTY_STORE = 2'd3
  } duty_sel_e;

  // result fields other than the compare value
  typedef struct packed {
    logic [7:0] led;
    mode_e      mode;
    logic [5:0] rec_tenths;
    logic [5:0] left_tenths;
    logic       playing;
  } res_t;

  typedef struct packed {
    duty_sel_e  sel;
    logic [9:0] table_val;
    res_t       res;
  } item_t;

  localparam int unsigned TicksPerTenthRec  = 1100;
  localparam int unsigned TicksPerTenthPlay = 1110;
  localparam int unsigned FullScale         = 1023;
  localparam int unsigned TenthsMax         = 63;
  localparam int unsigned NumWaves          = 8;
  localparam int unsigned WaveMaxLen        = 25;

  localparam logic [4:0] WAVE_LEN [NumWaves] = '{
    5'd25, 5'd22, 5'd21, 5'd19, 5'd17, 5'd16, 5'd14, 5'd13
  };

  // rows shorter than the longest are padded with zeros that are never read
  localparam logic [9:0] WAVE [NumWaves][WaveMaxLen] = '{
    '{10'h200, 10'h27f, 10'h2f6, 10'h35e, 10'h3af, 10'h3e6, 10'h3fe, 10'h3f6, 10'h3ce,
      10'h38a, 10'h32c, 10'h2bc, 10'h240, 10'h1bf, 10'h143, 10'h0d3, 10'h075, 10'h031,
      10'h009, 10'h001, 10'h019, 10'h050, 10'h0a1, 10'h109, 10'h180},
    '{10'h200, 10'h290, 10'h314, 10'h382, 10'h3d1, 10'h3fa, 10'h3fa, 10'h3d1, 10'h382,
      10'h314, 10'h290, 10'h200, 10'h16f, 10'h0eb, 10'h07d, 10'h02e, 10'h005, 10'h005,
      10'h02e, 10'h07d, 10'h0eb, 10'h16f, 10'h000, 10'h000, 10'h000},
    '{10'h200, 10'h296, 10'h320, 10'h38f, 10'h3dc, 10'h3fe, 10'h3f2, 10'h3ba, 10'h35b,
      10'h2dd, 10'h24c, 10'h1b3, 10'h122, 10'h0a4, 10'h045, 10'h00d, 10'h001, 10'h023,
      10'h070, 10'h0df, 10'h169, 10'h000, 10'h000, 10'h000, 10'h000},
    '{10'h200, 10'h2a6, 10'h33a, 10'h3ac, 10'h3ef, 10'h3fd, 10'h3d4, 10'h378, 10'h2f3,
      10'h254, 10'h1ab, 10'h10c, 10'h087, 10'h02b, 10'h002, 10'h010, 10'h053, 10'h0c5,
      10'h159, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000},
    '{10'h200, 10'h2b8, 10'h358, 10'h3c9, 10'h3fd, 10'h3eb, 10'h398, 10'h30d, 10'h25d,
      10'h1a2, 10'h0f2, 10'h067, 10'h014, 10'h002, 10'h036, 10'h0a7, 10'h147, 10'h000,
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000},
    '{10'h200, 10'h2c3, 10'h369, 10'h3d8, 10'h3ff, 10'h3d8, 10'h369, 10'h2c3, 10'h200,
      10'h13c, 10'h096, 10'h027, 10'h000, 10'h027, 10'h096, 10'h13c, 10'h000, 10'h000,
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000},
    '{10'h200, 10'h2dd, 10'h38f, 10'h3f2, 10'h3f2, 10'h38f, 10'h2dd, 10'h200, 10'h122,
      10'h070, 10'h00d, 10'h00d, 10'h070, 10'h122, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000},
    '{10'h200, 10'h2ed, 10'h3a4, 10'h3fb, 10'h3de, 10'h353, 10'h27a, 10'h185, 10'h0ac,
      10'h021, 10'h004, 10'h05b, 10'h112, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
      10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000}
  };

  function automatic logic [9:0] wave_sample(input logic [2:0] idx, input logic [4:0] ph);
    return WAVE[idx][ph];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wtrp_store.sv =====
// wtrp_store: sample store, one write port and one registered read port.
// Depends on nothing; instantiated by the top level.
`default_nettype none

module wtrp_store #(
  parameter int unsigned Depth = 65536,
  parameter int unsigned AddrW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [9:0]       wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [9:0]       rdata_o
);

  logic [9:0] mem [Depth];
  logic [9:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wtrp_ctrl.sv =====
// wtrp_ctrl: mode machine, button lock, counters and store addressing.
// Uses wtrp_pkg; drives the sample store and the duty pipeline.
`default_nettype none

module wtrp_ctrl #(
  parameter int unsigned StoreDepth = 65536,
  parameter int unsigned AddrW      = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       switches_i,
  input  wire logic             center_button_i,
  input  wire logic             right_button_i,
  input  wire logic [9:0]       mic_sample_i,
  output wtrp_pkg::item_t       item_o,
  output logic                  store_we_o,
  output logic      [AddrW-1:0] store_waddr_o,
  output logic      [9:0]       store_wdata_o,
  output logic                  store_re_o,
  output logic      [AddrW-1:0] store_raddr_o
);

  localparam int unsigned CntW = $clog2(StoreDepth + 1);
  localparam int unsigned NW   = wtrp_pkg::NumWaves;

  wtrp_pkg::mode_e mode_q, mode_d;
  logic            lock_q, lock_d;
  logic            rerec_q, rerec_d;
  logic            play_q, play_d;
  logic [31:0]     tick_q, tick_d;
  logic [4:0]      phase_q [NW];
  logic [4:0]      phase_d [NW];
  logic [10:0]     tmod_q, tmod_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [10:0]     rmod_q, rmod_d;
  logic [5:0]      trec_q, trec_d;
  logic [5:0]      tleft_q, tleft_d;
  logic [16:0]     limit_q, limit_d;
  logic [7:0]      led_q, led_d;

  logic            btc, btr;
  logic            play_start;
  logic            found;
  logic [2:0]      low;
  logic [31:0]     t_base, t_inc;
  logic [4:0]      ph_base [NW];
  logic [4:0]      ph_inc [NW];
  logic [10:0]     tm_base, tm_inc;
  logic            we, re;
  logic [AddrW-1:0] waddr;
  wtrp_pkg::duty_sel_e sel;
  logic [9:0]      tval;

  assign btc = center_button_i;
  assign btr = right_button_i;

  // playback start clears the tick count before the increment of the same item
  assign play_start = (mode_q == wtrp_pkg::MODE_PLAY) && btr && !lock_q;

  always_comb begin
    t_base  = play_start ? '0 : tick_q;
    tm_base = play_start ? '0 : tmod_q;
    t_inc   = t_base + 32'd1;
    tm_inc  = (t_inc == '0 || tm_base == 11'(wtrp_pkg::TicksPerTenthRec - 1)) ? '0
              : tm_base + 11'd1;
    for (int k = 0; k < NW; k++) begin
      ph_base[k] = play_start ? '0 : phase_q[k];
      // phases follow tick mod each table length, restarting when the tick wraps
      ph_inc[k]  = (t_inc == '0 || ph_base[k] == wtrp_pkg::WAVE_LEN[k] - 5'd1) ? '0
                   : ph_base[k] + 5'd1;
    end
  end

  // lowest active switch
  always_comb begin
    found = 1'b0;
    low   = '0;
    for (int k = NW - 1; k >= 0; k--) begin
      if (switches_i[k]) begin
        found = 1'b1;
        low   = 3'(k);
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    lock_d  = lock_q;
    rerec_d = rerec_q;
    play_d  = play_q;
    tick_d  = tick_q;
    phase_d = phase_q;
    tmod_d  = tmod_q;
    cnt_d   = cnt_q;
    rmod_d  = rmod_q;
    trec_d  = trec_q;
    tleft_d = tleft_q;
    limit_d = limit_q;
    led_d   = led_q;
    we      = 1'b0;
    waddr   = cnt_q[AddrW-1:0];
    re      = 1'b0;
    sel     = wtrp_pkg::DUTY_HOLD;
    tval    = '0;

    unique case (mode_q)
      wtrp_pkg::MODE_TONE: begin
        if (found) begin
          tick_d  = t_inc;
          phase_d = ph_inc;
          tmod_d  = tm_inc;
          sel     = wtrp_pkg::DUTY_TABLE;
          tval    = wtrp_pkg::wave_sample(low, ph_inc[low]);
          led_d   = 8'd1 << low;
        end else begin
          sel   = wtrp_pkg::DUTY_ZERO;
          led_d = '0;
        end
        if (btc && !lock_d) begin
          mode_d = wtrp_pkg::MODE_REC;
          tick_d = '0;
          for (int k = 0; k < NW; k++) begin
            phase_d[k] = '0;
          end
          tmod_d = '0;
          lock_d = 1'b1;
          sel    = wtrp_pkg::DUTY_ZERO;
          led_d  = '0;
        end
        if (!btr && lock_d && !btc) begin
          lock_d = 1'b0;
        end
      end

      wtrp_pkg::MODE_REC: begin
        if (btr && !lock_d) begin
          if (rerec_d) begin
            trec_d  = '0;
            cnt_d   = '0;
            rmod_d  = '0;
            rerec_d = 1'b0;
          end
          if (cnt_d < CntW'(StoreDepth)) begin
            we     = 1'b1;
            waddr  = cnt_d[AddrW-1:0];
            cnt_d  = cnt_d + 1'b1;
            rmod_d = (rmod_d == 11'(wtrp_pkg::TicksPerTenthRec - 1)) ? '0 : rmod_d + 11'd1;
          end
          led_d = led_d | 8'h04;
          if (cnt_d >= CntW'(StoreDepth)) begin
            lock_d = 1'b1;
          end
        end else begin
          led_d = led_d & ~8'h04;
        end
        if (!btr && cnt_d != '0 && !btc) begin
          rerec_d = 1'b1;
        end
        if (!btr && !btc) begin
          lock_d = 1'b0;
        end
        if (cnt_d != '0 && rmod_d == '0 && !lock_d && !rerec_d &&
            trec_d < 6'(wtrp_pkg::TenthsMax)) begin
          trec_d = trec_d + 6'd1;
        end
        if (btc && !lock_d) begin
          mode_d  = wtrp_pkg::MODE_PLAY;
          tleft_d = trec_d;
          limit_d = 17'(trec_d) * 17'(wtrp_pkg::TicksPerTenthPlay);
          lock_d  = 1'b1;
        end
      end

      wtrp_pkg::MODE_PLAY: begin
        if (play_start) begin
          play_d  = 1'b1;
          tick_d  = t_base;
          phase_d = ph_base;
          tmod_d  = tm_base;
          lock_d  = 1'b1;
        end
        if (limit_q == '0) begin
          play_d = 1'b0;
        end
        if (play_d) begin
          // past the take the sample reads as zero
          if (t_base < 32'(cnt_q) && t_base < 32'(StoreDepth)) begin
            re  = 1'b1;
            sel = wtrp_pkg::DUTY_STORE;
          end else begin
            sel = wtrp_pkg::DUTY_ZERO;
          end
          tick_d  = t_inc;
          phase_d = ph_inc;
          tmod_d  = tm_inc;
          if (t_inc == 32'(limit_q)) begin
            play_d = 1'b0;
          end
          if (t_inc != '0 && tm_inc == '0 && tleft_d != '0) begin
            tleft_d = tleft_d - 6'd1;
          end
        end else begin
          sel = wtrp_pkg::DUTY_ZERO;
        end
        if (!btr && lock_d && !btc && !play_d) begin
          lock_d  = 1'b0;
          tleft_d = trec_q;
        end
        if (btc && !lock_d) begin
          mode_d = wtrp_pkg::MODE_TONE;
          lock_d = 1'b1;
        end
      end

      default: begin
        sel = wtrp_pkg::DUTY_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= wtrp_pkg::MODE_TONE;
      lock_q  <= 1'b0;
      rerec_q <= 1'b0;
      play_q  <= 1'b0;
      tick_q  <= '0;
      for (int k = 0; k < NW; k++) begin
        phase_q[k] <= '0;
      end
      tmod_q  <= '0;
      cnt_q   <= '0;
      rmod_q  <= '0;
      trec_q  <= '0;
      tleft_q <= '0;
      limit_q <= '0;
      led_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      lock_q  <= lock_d;
      rerec_q <= rerec_d;
      play_q  <= play_d;
      tick_q  <= tick_d;
      phase_q <= phase_d;
      tmod_q  <= tmod_d;
      cnt_q   <= cnt_d;
      rmod_q  <= rmod_d;
      trec_q  <= trec_d;
      tleft_q <= tleft_d;
      limit_q <= limit_d;
      led_q   <= led_d;
    end
  end

  assign store_we_o    = accept_i && we;
  assign store_waddr_o = waddr;
  assign store_wdata_o = mic_sample_i;
  assign store_re_o    = accept_i && re;
  assign store_raddr_o = t_base[AddrW-1:0];

  assign item_o.sel             = sel;
  assign item_o.table_val       = tval;
  assign item_o.res.led         = led_d;
  assign item_o.res.mode        = mode_d;
  assign item_o.res.rec_tenths  = trec_d;
  assign item_o.res.left_tenths = tleft_d;
  assign item_o.res.playing     = play_d;

endmodule

`default_nettype wire

// ===== hw/rtl/wtrp_duty.sv =====
// wtrp_duty: period register and the elastic pipeline that scales a sample
// to the PWM compare value and holds the result item. Uses wtrp_pkg.
`default_nettype none

module wtrp_duty (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [15:0]     cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wtrp_pkg::item_t      item_i,
  input  wire logic [9:0]      store_rdata_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic      [16:0]     compare_value_o,
  output wtrp_pkg::res_t       res_o
);

  // period plus one, kept ready for the multiplier
  logic [16:0] pp1_q;

  logic                s1_v_q, s2_v_q, s3_v_q, out_v_q;
  wtrp_pkg::item_t     s1_q;
  wtrp_pkg::duty_sel_e s2_sel_q, s3_sel_q;
  wtrp_pkg::res_t      s2_res_q, s3_res_q, out_res_q;
  logic [26:0]         prod_q, x_q;
  logic [17:0]         q0_q;
  logic [16:0]         duty_q;

  logic        r1, r2, r3, r_out;
  logic [9:0]  samp;
  logic [26:0] prod_d;
  logic [27:0] est;
  logic [27:0] qm, rem;
  logic [16:0] quot;

  assign r_out      = !out_v_q || out_ready_i;
  assign r3         = r_out;
  assign r2         = !s3_v_q || r3;
  assign r1         = !s2_v_q || r2;
  assign in_ready_o = !s1_v_q || r1;

  assign samp   = (s1_q.sel == wtrp_pkg::DUTY_STORE) ? store_rdata_i : s1_q.table_val;
  assign prod_d = {10'd0, pp1_q} * {17'd0, samp};

  // x/1023 from below: x/1024 + x/2^20 + x/2^30 falls short by at most one
  assign est  = {1'b0, prod_q} + {11'd0, prod_q[26:10]} + {21'd0, prod_q[26:20]};
  assign qm   = {q0_q[17:0], 10'd0} - {10'd0, q0_q};
  assign rem  = {1'b0, x_q} - qm;
  assign quot = (rem >= 28'(wtrp_pkg::FullScale)) ? q0_q[16:0] + 17'd1 : q0_q[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp1_q   <= 17'd227;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      duty_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        pp1_q <= {1'b0, cfg_wdata_i} + 17'd1;
      end
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
      if (r1) begin
        s2_v_q <= s1_v_q;
      end
      if (r2) begin
        s3_v_q <= s2_v_q;
      end
      if (r3) begin
        out_v_q <= s3_v_q;
        if (s3_v_q) begin
          case (s3_sel_q)
            wtrp_pkg::DUTY_ZERO: duty_q <= '0;
            wtrp_pkg::DUTY_HOLD: duty_q <= duty_q;
            default:             duty_q <= quot;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= item_i;
    end
    if (r1 && s1_v_q) begin
      s2_sel_q <= s1_q.sel;
      s2_res_q <= s1_q.res;
      prod_q   <= prod_d;
    end
    if (r2 && s2_v_q) begin
      s3_sel_q <= s2_sel_q;
      s3_res_q <= s2_res_q;
      x_q      <= prod_q;
      q0_q     <= est[27:10];
    end
    if (r3 && s3_v_q) begin
      out_res_q <= s3_res_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign compare_value_o = duty_q;
  assign res_o           = out_res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wavetable_tone_record_playback.sv =====
// Wavetable tone, voice record and playback block with PWM compare output.
// Takes one item per clock cycle while the output side does not stall; each
// result passes through the store read, the multiply and two scaling
// steps, with a stage buffer between each so either side may stall. The
// state update of an item happens in its accept cycle, and the sample store
// is read or written once per item, so back-to-back items never contend for
// the store. The store needs no clearing after reset: reads past the
// recorded count give sample zero. The compare value is
// floor((pwm_period+1)*s/1023), with pwm_period written on cfg_we_i.
// Depends on wtrp_pkg, wtrp_ctrl, wtrp_store and wtrp_duty.
`default_nettype none

module wavetable_tone_record_playback #(
  parameter int unsigned STORE_DEPTH = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  switches_i,
  input  wire logic        center_button_i,
  input  wire logic        right_button_i,
  input  wire logic [9:0]  mic_sample_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [16:0] compare_value_o,
  output logic      [7:0]  led_pattern_o,
  output logic      [1:0]  current_mode_o,
  output logic      [5:0]  recorded_tenths_o,
  output logic      [5:0]  remaining_tenths_o,
  output logic             playing_o
);

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);

  logic             accept;
  wtrp_pkg::item_t  item;
  wtrp_pkg::res_t   res;
  logic             st_we, st_re;
  logic [AddrW-1:0] st_waddr, st_raddr;
  logic [9:0]       st_wdata, st_rdata;

  assign accept = in_valid_i && in_ready_o;

  wtrp_ctrl #(
    .StoreDepth (STORE_DEPTH),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .switches_i      (switches_i),
    .center_button_i (center_button_i),
    .right_button_i  (right_button_i),
    .mic_sample_i    (mic_sample_i),
    .item_o          (item),
    .store_we_o      (st_we),
    .store_waddr_o   (st_waddr),
    .store_wdata_o   (st_wdata),
    .store_re_o      (st_re),
    .store_raddr_o   (st_raddr)
  );

  wtrp_store #(
    .Depth (STORE_DEPTH),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  wtrp_duty u_duty (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .item_i          (item),
    .store_rdata_i   (st_rdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .compare_value_o (compare_value_o),
    .res_o           (res)
  );

  assign led_pattern_o      = res.led;
  assign current_mode_o     = res.mode;
  assign recorded_tenths_o  = res.rec_tenths;
  assign remaining_tenths_o = res.left_tenths;
  assign playing_o          = res.playing;

endmodule

`default_nettype wire

// ===== dv/wavetable_tone_record_playback_tb.sv =====
// Testbench for wavetable_tone_record_playback: directed and random audio ticks, an
// in-bench player model that predicts every output frame, and a scoreboard on the result port.
// Depends on wtrp_pkg and the wavetable_tone_record_playback RTL.
module wavetable_tone_record_playback_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wtrp_pkg::*;

  localparam int unsigned ClkPeriod      = 8;
  localparam int unsigned StoreDepth     = 65536;
  localparam int unsigned RecTenthTicks  = 1100;
  localparam int unsigned PlayTenthTicks = 1110;
  localparam int unsigned DutyFullScale  = 1023;
  localparam int unsigned TenthsCap      = 63;
  localparam int unsigned RandomTicks    = 950;
  localparam int unsigned DrainCycles    = 12;
  localparam int unsigned TimeoutNs      = 50_000_000;

  // own copy of the tone tables, short rows padded with zeros
  localparam logic [9:0] ToneWave [8][25] = '{
    '{'h200, 'h27f, 'h2f6, 'h35e, 'h3af, 'h3e6, 'h3fe, 'h3f6, 'h3ce, 'h38a, 'h32c, 'h2bc,
      'h240, 'h1bf, 'h143, 'h0d3, 'h075, 'h031, 'h009, 'h001, 'h019, 'h050, 'h0a1, 'h109,
      'h180},
    '{'h200, 'h290, 'h314, 'h382, 'h3d1, 'h3fa, 'h3fa, 'h3d1, 'h382, 'h314, 'h290, 'h200,
      'h16f, 'h0eb, 'h07d, 'h02e, 'h005, 'h005, 'h02e, 'h07d, 'h0eb, 'h16f, 'h000, 'h000,
      'h000},
    '{'h200, 'h296, 'h320, 'h38f, 'h3dc, 'h3fe, 'h3f2, 'h3ba, 'h35b, 'h2dd, 'h24c, 'h1b3,
      'h122, 'h0a4, 'h045, 'h00d, 'h001, 'h023, 'h070, 'h0df, 'h169, 'h000, 'h000, 'h000,
      'h000},
    '{'h200, 'h2a6, 'h33a, 'h3ac, 'h3ef, 'h3fd, 'h3d4, 'h378, 'h2f3, 'h254, 'h1ab, 'h10c,
      'h087, 'h02b, 'h002, 'h010, 'h053, 'h0c5, 'h159, 'h000, 'h000, 'h000, 'h000, 'h000,
      'h000},
    '{'h200, 'h2b8, 'h358, 'h3c9, 'h3fd, 'h3eb, 'h398, 'h30d, 'h25d, 'h1a2, 'h0f2, 'h067,
      'h014, 'h002, 'h036, 'h0a7, 'h147, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000,
      'h000},
    '{'h200, 'h2c3, 'h369, 'h3d8, 'h3ff, 'h3d8, 'h369, 'h2c3, 'h200, 'h13c, 'h096, 'h027,
      'h000, 'h027, 'h096, 'h13c, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000,
      'h000},
    '{'h200, 'h2dd, 'h38f, 'h3f2, 'h3f2, 'h38f, 'h2dd, 'h200, 'h122, 'h070, 'h00d, 'h00d,
      'h070, 'h122, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000,
      'h000},
    '{'h200, 'h2ed, 'h3a4, 'h3fb, 'h3de, 'h353, 'h27a, 'h185, 'h0ac, 'h021, 'h004, 'h05b,
      'h112, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000, 'h000,
      'h000}
  };
  localparam int unsigned ToneLen [8] = '{25, 22, 21, 19, 17, 16, 14, 13};

  typedef struct packed {
    logic [7:0] sw;
    logic       center;
    logic       right;
    logic [9:0] mic;
  } tick_t;

  typedef struct packed {
    logic [16:0] duty;
    logic [7:0]  led;
    logic [1:0]  mode;
    logic [5:0]  rec_tenths;
    logic [5:0]  left_tenths;
    logic        playing;
  } frame_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [15:0] cfg_wdata_i     = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  switches_i      = '0;
  logic        center_button_i = 1'b0;
  logic        right_button_i  = 1'b0;
  logic [9:0]  mic_sample_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [16:0] compare_value_o;
  logic [7:0]  led_pattern_o;
  logic [1:0]  current_mode_o;
  logic [5:0]  recorded_tenths_o;
  logic [5:0]  remaining_tenths_o;
  logic        playing_o;

  wavetable_tone_record_playback #(
    .STORE_DEPTH(StoreDepth)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .switches_i         (switches_i),
    .center_button_i    (center_button_i),
    .right_button_i     (right_button_i),
    .mic_sample_i       (mic_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .compare_value_o    (compare_value_o),
    .led_pattern_o      (led_pattern_o),
    .current_mode_o     (current_mode_o),
    .recorded_tenths_o  (recorded_tenths_o),
    .remaining_tenths_o (remaining_tenths_o),
    .playing_o          (playing_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // player model state
  logic [15:0]  period_q = 16'd226;
  mode_e        mode_q   = MODE_TONE;
  bit           lock_q, rerec_q, active_q;
  logic [31:0]  ticks_q;
  int unsigned  count_q, rec_tenths_q, left_tenths_q, limit_q;
  logic [7:0]   led_q;
  logic [16:0]  duty_q;
  logic [9:0]   store_q [StoreDepth];

  frame_t       pending_frames [$];
  frame_t       head;
  int unsigned  fail_count  = 0;
  int unsigned  ticks_sent  = 0;
  int unsigned  burst_left  = 0;
  bit           quiet_mode  = 1'b0;
  int unsigned  stall_window = 0;
  int unsigned  stall_pct    = 0;

  initial begin
    lock_q        = 1'b0;
    rerec_q       = 1'b0;
    active_q      = 1'b0;
    ticks_q       = '0;
    count_q       = 0;
    rec_tenths_q  = 0;
    left_tenths_q = 0;
    limit_q       = 0;
    led_q         = '0;
    duty_q        = '0;
  end

  function automatic logic [16:0] scale_sample(input logic [9:0] s);
    longint unsigned span;
    span = period_q;
    span = span + 1;
    return 17'((span * s) / DutyFullScale);
  endfunction

  function automatic void advance_player(input tick_t t);
    int unsigned idx;
    bit          found;
    logic [9:0]  s;
    frame_t      f;
    idx   = 0;
    found = 1'b0;
    case (mode_q)
      MODE_TONE: begin
        for (int i = 0; i < 8; i++) begin
          if (!found && t.sw[i]) begin
            found = 1'b1;
            idx   = i;
          end
        end
        if (found) begin
          ticks_q = ticks_q + 1;
          duty_q  = scale_sample(ToneWave[idx][ticks_q % ToneLen[idx]]);
          led_q   = 8'(1 << idx);
        end else begin
          duty_q = '0;
          led_q  = '0;
        end
        if (t.center && !lock_q) begin
          mode_q  = MODE_REC;
          ticks_q = '0;
          lock_q  = 1'b1;
          duty_q  = '0;
          led_q   = '0;
        end
        if (!t.right && lock_q && !t.center) lock_q = 1'b0;
      end
      MODE_REC: begin
        if (t.right && !lock_q) begin
          if (rerec_q) begin
            rec_tenths_q = 0;
            count_q      = 0;
            rerec_q      = 1'b0;
          end
          if (count_q < StoreDepth) begin
            count_q = count_q + 1;
            store_q[count_q - 1] = t.mic;
          end
          led_q[2] = 1'b1;
          if (count_q >= StoreDepth) lock_q = 1'b1;
        end else begin
          led_q[2] = 1'b0;
        end
        if (!t.right && count_q != 0 && !t.center) rerec_q = 1'b1;
        if (!t.right && !t.center) lock_q = 1'b0;
        if (count_q != 0 && (count_q % RecTenthTicks) == 0 && !lock_q && !rerec_q &&
            rec_tenths_q < TenthsCap) begin
          rec_tenths_q = rec_tenths_q + 1;
        end
        if (t.center && !lock_q) begin
          mode_q        = MODE_PLAY;
          left_tenths_q = rec_tenths_q;
          limit_q       = rec_tenths_q * PlayTenthTicks;
          lock_q        = 1'b1;
        end
      end
      MODE_PLAY: begin
        if (t.right && !lock_q) begin
          active_q = 1'b1;
          ticks_q  = '0;
          lock_q   = 1'b1;
        end
        if (limit_q == 0) active_q = 1'b0;
        if (active_q) begin
          s = '0;
          // reads past the take give silence
          if (ticks_q < count_q && ticks_q < StoreDepth) s = store_q[ticks_q[15:0]];
          ticks_q = ticks_q + 1;
          if (ticks_q == limit_q) active_q = 1'b0;
          if (ticks_q != 0 && (ticks_q % RecTenthTicks) == 0 && left_tenths_q > 0) begin
            left_tenths_q = left_tenths_q - 1;
          end
          duty_q = scale_sample(s);
        end else begin
          duty_q = '0;
        end
        if (!t.right && lock_q && !t.center && !active_q) begin
          lock_q        = 1'b0;
          left_tenths_q = rec_tenths_q;
        end
        if (t.center && !lock_q) begin
          mode_q = MODE_TONE;
          lock_q = 1'b1;
        end
      end
      default: ;
    endcase
    f.duty        = duty_q;
    f.led         = led_q;
    f.mode        = mode_q;
    f.rec_tenths  = 6'(rec_tenths_q);
    f.left_tenths = 6'(left_tenths_q);
    f.playing     = active_q;
    pending_frames.push_back(f);
    ticks_sent++;
  endfunction

  function automatic tick_t make_tick(input logic [7:0] sw, input logic center,
                                      input logic right, input logic [9:0] mic);
    tick_t t;
    t.sw     = sw;
    t.center = center;
    t.right  = right;
    t.mic    = mic;
    return t;
  endfunction

  function automatic logic [7:0] rand_sw();
    case ($urandom_range(0, 3))
      0:       return 8'(1 << $urandom_range(0, 7));
      1:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [9:0] pick_mic();
    case ($urandom_range(0, 9))
      0:       return 10'h000;
      1:       return 10'h3ff;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic logic [15:0] pick_period();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic tick_t quiet_tick();
    return make_tick(rand_sw(), 1'b0, 1'b0, pick_mic());
  endfunction

  // sender: bursts of items with random gaps; valid stays up between items of a burst
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = quiet_mode ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    switches_i      <= t.sw;
    center_button_i <= t.center;
    right_button_i  <= t.right;
    mic_sample_i    <= t.mic;
    do @(posedge clk_i); while (!in_ready_o);
    advance_player(t);
  endtask

  task automatic drain_player();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_pwm_period(input logic [15:0] value);
    drain_player();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    period_q = value;
  endtask

  task automatic press_center();
    send_tick(make_tick(rand_sw(), 1'b1, 1'b0, pick_mic()));
    send_tick(quiet_tick());
  endtask

  task automatic enter_mode(input mode_e m);
    while (mode_q != m) press_center();
  endtask

  // hold the right button for n items; optionally leave on the next item
  task automatic record_take(input int unsigned n, input bit leave_now);
    repeat (n) send_tick(make_tick(rand_sw(), 1'b0, 1'b1, pick_mic()));
    if (leave_now) send_tick(make_tick(rand_sw(), 1'b1, 1'b0, pick_mic()));
    send_tick(quiet_tick());
  endtask

  task automatic play_through();
    send_tick(make_tick(rand_sw(), 1'b0, 1'b1, pick_mic()));
    send_tick(quiet_tick());
    while (active_q) begin
      // stray right presses are locked out while the take plays
      send_tick(make_tick(rand_sw(), 1'b0, logic'($urandom_range(0, 199) == 0), pick_mic()));
    end
    send_tick(quiet_tick());
  endtask

  task automatic test_directed();
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 10'h000));
    for (int i = 0; i < 8; i++) send_tick(make_tick(8'(1 << i), 1'b0, 1'b0, pick_mic()));
    send_tick(make_tick(8'hff, 1'b0, 1'b0, 10'h3ff));
    send_tick(make_tick(8'ha0, 1'b0, 1'b0, 10'h000));
    // leave tone mode with a switch still on
    send_tick(make_tick(8'hff, 1'b1, 1'b0, 10'h3ff));
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 10'h000));
    send_tick(make_tick(8'h00, 1'b0, 1'b1, 10'h3ff));
    send_tick(make_tick(8'h00, 1'b0, 1'b1, 10'h000));
    send_tick(make_tick(8'h00, 1'b0, 1'b1, 10'h155));
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 10'h2aa));
    // take shorter than a tenth: playback stops at once
    send_tick(make_tick(8'h00, 1'b1, 1'b0, 10'h000));
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 10'h000));
    send_tick(make_tick(8'h00, 1'b0, 1'b1, 10'h000));
    send_tick(make_tick(8'h00, 1'b0, 1'b0, 10'h000));
    send_tick(make_tick(8'h01, 1'b1, 1'b0, 10'h000));
    send_tick(make_tick(8'h01, 1'b0, 1'b0, 10'h000));
  endtask

  task automatic test_tone_periods();
    logic [15:0] periods [5];
    periods = '{16'h0000, 16'hffff, 16'h0001, 16'd226, 16'($urandom_range(0, 65535))};
    foreach (periods[k]) begin
      set_pwm_period(periods[k]);
      enter_mode(MODE_TONE);
      repeat (40) send_tick(quiet_tick());
    end
  endtask

  task automatic test_record_playback();
    int unsigned take_len [4];
    take_len = '{RecTenthTicks, RecTenthTicks - 1,
                 2 * RecTenthTicks + $urandom_range(0, 300), RecTenthTicks + 1};
    set_pwm_period(pick_period());
    foreach (take_len[k]) begin
      enter_mode(MODE_REC);
      // a short take that the next press starts over
      record_take($urandom_range(1, 20), 1'b0);
      // first take leaves on the item after a full tenth, which counts once more
      record_take(take_len[k], k == 0);
      enter_mode(MODE_PLAY);
      play_through();
      if (k == 2) play_through();
    end
    enter_mode(MODE_TONE);
  endtask

  task automatic test_full_store();
    set_pwm_period(16'hffff);
    quiet_mode = 1'b1;
    enter_mode(MODE_REC);
    record_take(StoreDepth + 40, 1'b0);
    quiet_mode = 1'b0;
    enter_mode(MODE_PLAY);
    play_through();
    enter_mode(MODE_TONE);
  endtask

  task automatic test_random_ticks();
    int unsigned start;
    start = ticks_sent;
    while (ticks_sent - start < RandomTicks) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // noise with both buttons at random
          repeat ($urandom_range(1, 12)) begin
            send_tick(make_tick(8'($urandom_range(0, 255)),
                                logic'($urandom_range(0, 99) < 15),
                                logic'($urandom_range(0, 99) < 35), pick_mic()));
          end
        end
        3: press_center();
        4, 5: begin
          if (mode_q == MODE_REC) record_take($urandom_range(1, 80), $urandom_range(0, 3) == 0);
          else enter_mode(MODE_REC);
        end
        6: begin
          if (mode_q == MODE_PLAY) play_through();
          else enter_mode(MODE_PLAY);
        end
        7, 8: begin
          if (mode_q == MODE_TONE) repeat ($urandom_range(5, 40)) send_tick(quiet_tick());
          else enter_mode(MODE_TONE);
        end
        default: begin
          if ($urandom_range(0, 2) == 0) set_pwm_period(pick_period());
        end
      endcase
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // receiver stalls in windows of random length and density
  always @(posedge clk_i) begin
    if (stall_window == 0) begin
      stall_window = $urandom_range(8, 64);
      case ($urandom_range(0, 3))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 30;
        default: stall_pct = 70;
      endcase
    end
    stall_window--;
    out_ready_i <= quiet_mode || ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        $error("result item with no item pending");
        fail_count++;
      end else begin
        head = pending_frames.pop_front();
        check_field("compare_value", head.duty, compare_value_o);
        check_field("led_pattern", head.led, led_pattern_o);
        check_field("current_mode", head.mode, current_mode_o);
        check_field("recorded_tenths", head.rec_tenths, recorded_tenths_o);
        check_field("remaining_tenths", head.left_tenths, remaining_tenths_o);
        check_field("playing", head.playing, playing_o);
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tone_periods();
    test_record_playback();
    test_full_store();
    test_random_ticks();
    drain_player();
    if (fail_count == 0 && pending_frames.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wtrp_pkg.sv
hw/rtl/wtrp_store.sv
hw/rtl/wtrp_ctrl.sv
hw/rtl/wtrp_duty.sv
hw/rtl/wavetable_tone_record_playback.sv
dv/wavetable_tone_record_playback_tb.sv
